@@ design/lzwd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the LZW decoder.
package lzwd_pkg;

  localparam int SIZE_W = 25;

  localparam logic [8:0] CODE_CLEAR = 9'h100;
  localparam logic [8:0] CODE_STOP  = 9'h101;
  localparam logic [8:0] CODE_FIRST = 9'h102;
  localparam logic [3:0] START_WIDTH = 4'd9;

  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_PULL    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_BYTE    = 3'd2;
  localparam logic [2:0] ST_NEED    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_FAIL    = 3'd5;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_START   = 3'd1;
  localparam logic [2:0] ERR_BIG     = 3'd2;
  localparam logic [2:0] ERR_FULL    = 3'd3;
  localparam logic [2:0] ERR_OVERRUN = 3'd4;
  localparam logic [2:0] ERR_LENGTH  = 3'd5;
  localparam logic [2:0] ERR_TRUNC   = 3'd6;
  localparam logic [2:0] ERR_SPECIAL = 3'd7;

  localparam logic ADDR_EXPECTED = 1'b0;

  typedef enum logic [1:0] {
    PH_START,
    PH_RUN,
    PH_DONE,
    PH_FAIL
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHAIN,
    S_WALK,
    S_SPEC,
    S_CHECK,
    S_POP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        out_byte;
    logic [2:0]        error_kind;
    logic [SIZE_W-1:0] bytes_written;
  } out_item_t;

endpackage

@@ design/lzw_decompressor_9_to_12_bit.sv @@
`timescale 1ns / 1ps
// LZW stream decoder top level: bit unpacker, dictionary walk, reverse stack.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+--------------------------------
//  in       | in  | in_valid_i / in_ready_o | lzwd_pkg::in_item_t
//  out      | out | out_valid_o/out_ready_i | lzwd_pkg::out_item_t
//  config   | in  | psel/penable/pwrite     | expected_size at byte addr 0
//
// Push, end mark, restart and items in a finished stream are answered from idle.
// Pull with bytes on the stack: stack RAM read, then result.
// Pull that decodes a code: fetch, then a chain step per byte of the expanded
// string and a walk step per dictionary link, one more step for KwKwK and one
// fetch per clear code skipped; the dictionary RAM read sits in the chain walk.
// rst_ni clears all control state at once; no clearing pass is needed.
// A result waits in the output register; a stalled out side holds the
// sequencer before it loads the next result.
module lzw_decompressor_9_to_12_bit #(
  parameter int MAX_CODES     = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lzwd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lzwd_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW   = $clog2(MAX_CODES);
  localparam int CBW  = MAX_CODE_BITS;
  localparam int BBW  = CBW + 7;
  localparam int BCW  = $clog2(BBW + 1);
  localparam int WW   = $clog2(CBW + 1);
  localparam int NW   = ((AW + 1) > (CBW + 1)) ? (AW + 1) : (CBW + 1);
  localparam int DW   = CBW + 8;
  localparam int SZW  = lzwd_pkg::SIZE_W;
  localparam int SUMW = SZW + 1;

  // config
  logic [SZW-1:0] expected_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lzwd_pkg::ADDR_EXPECTED);
  assign prdata = (paddr[2] == lzwd_pkg::ADDR_EXPECTED) ? 32'(expected_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (cfg_wr) begin
      expected_q <= pwdata[SZW-1:0];
    end
  end

  // stream state
  lzwd_pkg::state_e state_q, state_d;
  lzwd_pkg::phase_e phase_q, phase_d;
  logic [BBW-1:0] bbuf_q, bbuf_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [WW-1:0]  cw_q, cw_d;
  logic [AW:0]    next_q, next_d;
  logic [CBW-1:0] prev_q, prev_d;
  logic [7:0]     first_q, first_d;
  logic [AW:0]    depth_q, depth_d;
  logic [SZW-1:0] cnt_q, cnt_d;
  logic [2:0]     err_q, err_d;
  logic           ended_q, ended_d;
  // walk registers
  logic [CBW-1:0] c_q, c_d;
  logic [CBW-1:0] code_q, code_d;
  logic [AW:0]    n_q, n_d;
  logic           spec_q, spec_d;
  logic           bpend_q, bpend_d;
  // output register
  logic                out_valid_q;
  lzwd_pkg::out_item_t out_q, out_d;
  logic                out_load;

  // memories
  logic [DW-1:0] dict_mem [MAX_CODES];
  logic [7:0]    stk_mem  [MAX_CODES];
  logic [DW-1:0] dict_rd_q;
  logic [7:0]    stk_rd_q;
  logic          dict_we, stk_we;
  logic [AW-1:0] dict_wa, stk_wa;
  logic [DW-1:0] dict_wd;
  logic [7:0]    stk_wd;
  logic [AW-1:0] dict_ra, stk_ra;

  assign dict_ra = AW'(NW'(c_q));
  assign stk_ra  = AW'(depth_q - (AW + 1)'(1));

  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[dict_wa] <= dict_wd;
    end
    dict_rd_q <= dict_mem[dict_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  // datapath helpers
  logic           slot_free;
  logic [BBW-1:0] cmask;
  logic [CBW-1:0] code;
  logic [NW-1:0]  code_n, next_n, c_n;
  logic           special;
  logic [CBW-1:0] src;
  logic [AW:0]    base;
  logic [SUMW-1:0] sum_base, sum_n, exp_w;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lzwd_pkg::S_IDLE) && slot_free;
  assign cmask    = (BBW'(1) << cw_q) - BBW'(1);
  assign code     = CBW'(bbuf_q & cmask);
  assign code_n   = NW'(code);
  assign next_n   = NW'(next_q);
  assign c_n      = NW'(c_q);
  assign special  = (code_n == next_n);
  assign src      = special ? prev_q : code;
  assign base     = n_q - (AW + 1)'(spec_q);
  assign exp_w    = SUMW'(expected_q);
  assign sum_base = SUMW'(cnt_q) + SUMW'(base);
  assign sum_n    = SUMW'(cnt_q) + SUMW'(n_q);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    bbuf_d  = bbuf_q;
    bcnt_d  = bcnt_q;
    cw_d    = cw_q;
    next_d  = next_q;
    prev_d  = prev_q;
    first_d = first_q;
    depth_d = depth_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    ended_d = ended_q;
    c_d     = c_q;
    code_d  = code_q;
    n_d     = n_q;
    spec_d  = spec_q;
    bpend_d = bpend_q;
    out_load = 1'b0;
    out_d    = out_q;
    dict_we = 1'b0;
    dict_wa = AW'(next_q);
    dict_wd = {prev_q, first_q};
    stk_we  = 1'b0;
    stk_wa  = AW'(n_q);
    stk_wd  = 8'd0;

    unique case (state_q)
      lzwd_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          priority if (in_data_i.kind == lzwd_pkg::KIND_RESTART) begin
            phase_d = lzwd_pkg::PH_START;
            bbuf_d  = '0;
            bcnt_d  = '0;
            cw_d    = WW'(lzwd_pkg::START_WIDTH);
            next_d  = (AW + 1)'(lzwd_pkg::CODE_FIRST);
            prev_d  = CBW'(lzwd_pkg::CODE_CLEAR);
            first_d = '0;
            depth_d = '0;
            cnt_d   = '0;
            err_d   = lzwd_pkg::ERR_NONE;
            ended_d = 1'b0;
            out_load = 1'b1;
            out_d = '{lzwd_pkg::ST_OK, 8'd0, lzwd_pkg::ERR_NONE, '0};
          end else if (phase_q == lzwd_pkg::PH_DONE || phase_q == lzwd_pkg::PH_FAIL) begin
            out_load = 1'b1;
            out_d = '{(phase_q == lzwd_pkg::PH_DONE) ? lzwd_pkg::ST_DONE : lzwd_pkg::ST_FAIL,
                      8'd0, err_q, cnt_q};
          end else if (in_data_i.kind == lzwd_pkg::KIND_PUSH) begin
            out_load = 1'b1;
            if (ended_q || bcnt_q > BCW'(CBW - 1)) begin
              out_d = '{lzwd_pkg::ST_REFUSED, 8'd0, err_q, cnt_q};
            end else begin
              bbuf_d = bbuf_q | (BBW'(in_data_i.data_byte) << bcnt_q);
              bcnt_d = bcnt_q + BCW'(8);
              out_d = '{lzwd_pkg::ST_OK, 8'd0, err_q, cnt_q};
            end
          end else if (in_data_i.kind == lzwd_pkg::KIND_END) begin
            ended_d = 1'b1;
            out_load = 1'b1;
            out_d = '{lzwd_pkg::ST_OK, 8'd0, err_q, cnt_q};
          end else begin
            state_d = (depth_q != '0) ? lzwd_pkg::S_POP : lzwd_pkg::S_FETCH;
          end
        end
      end

      lzwd_pkg::S_FETCH: begin
        priority if (depth_q != '0) begin
          state_d = lzwd_pkg::S_POP;
        end else if (phase_q == lzwd_pkg::PH_DONE || phase_q == lzwd_pkg::PH_FAIL) begin
          state_d = lzwd_pkg::S_RESP;
        end else if (bcnt_q < BCW'(cw_q)) begin
          if (ended_q) begin
            phase_d = lzwd_pkg::PH_FAIL;
            err_d   = lzwd_pkg::ERR_TRUNC;
          end
          state_d = lzwd_pkg::S_RESP;
        end else begin
          bbuf_d = bbuf_q >> cw_q;
          bcnt_d = bcnt_q - BCW'(cw_q);
          priority if (phase_q == lzwd_pkg::PH_START) begin
            if (code == CBW'(lzwd_pkg::CODE_STOP)) begin
              if (expected_q == '0) begin
                phase_d = lzwd_pkg::PH_DONE;
              end else begin
                phase_d = lzwd_pkg::PH_FAIL;
                err_d   = lzwd_pkg::ERR_LENGTH;
              end
            end else if (code == CBW'(lzwd_pkg::CODE_CLEAR)) begin
              cw_d    = WW'(lzwd_pkg::START_WIDTH);
              next_d  = (AW + 1)'(lzwd_pkg::CODE_FIRST);
              prev_d  = CBW'(lzwd_pkg::CODE_CLEAR);
              phase_d = lzwd_pkg::PH_RUN;
            end else begin
              phase_d = lzwd_pkg::PH_FAIL;
              err_d   = lzwd_pkg::ERR_START;
            end
          end else if (code == CBW'(lzwd_pkg::CODE_STOP)) begin
            if (cnt_q == expected_q) begin
              phase_d = lzwd_pkg::PH_DONE;
            end else begin
              phase_d = lzwd_pkg::PH_FAIL;
              err_d   = lzwd_pkg::ERR_LENGTH;
            end
          end else if (code == CBW'(lzwd_pkg::CODE_CLEAR)) begin
            cw_d   = WW'(lzwd_pkg::START_WIDTH);
            next_d = (AW + 1)'(lzwd_pkg::CODE_FIRST);
            prev_d = CBW'(lzwd_pkg::CODE_CLEAR);
          end else if (code_n > next_n) begin
            phase_d = lzwd_pkg::PH_FAIL;
            err_d   = lzwd_pkg::ERR_BIG;
          end else if (src == CBW'(lzwd_pkg::CODE_CLEAR)) begin
            phase_d = lzwd_pkg::PH_FAIL;
            err_d   = lzwd_pkg::ERR_SPECIAL;
          end else begin
            c_d     = src;
            code_d  = code;
            n_d     = (AW + 1)'(special);
            spec_d  = special;
            state_d = lzwd_pkg::S_CHAIN;
          end
        end
      end

      lzwd_pkg::S_CHAIN: begin
        if (c_n >= NW'(lzwd_pkg::CODE_FIRST)) begin
          if (32'(c_n) >= MAX_CODES || 32'(n_q) >= MAX_CODES) begin
            phase_d = lzwd_pkg::PH_FAIL;
            err_d   = lzwd_pkg::ERR_BIG;
            depth_d = '0;
            state_d = lzwd_pkg::S_RESP;
          end else begin
            state_d = lzwd_pkg::S_WALK;
          end
        end else if (c_n > NW'(8'hff) || 32'(n_q) >= MAX_CODES) begin
          phase_d = lzwd_pkg::PH_FAIL;
          err_d   = lzwd_pkg::ERR_BIG;
          depth_d = '0;
          state_d = lzwd_pkg::S_RESP;
        end else begin
          stk_we  = 1'b1;
          stk_wd  = c_q[7:0];
          n_d     = n_q + (AW + 1)'(1);
          first_d = c_q[7:0];
          state_d = spec_q ? lzwd_pkg::S_SPEC : lzwd_pkg::S_CHECK;
        end
      end

      lzwd_pkg::S_WALK: begin
        stk_we  = 1'b1;
        stk_wd  = dict_rd_q[7:0];
        n_d     = n_q + (AW + 1)'(1);
        c_d     = dict_rd_q[DW-1:8];
        state_d = lzwd_pkg::S_CHAIN;
      end

      lzwd_pkg::S_SPEC: begin
        // KwKwK: slot 0 repeats the string's first byte
        stk_we  = 1'b1;
        stk_wa  = '0;
        stk_wd  = first_q;
        state_d = lzwd_pkg::S_CHECK;
      end

      lzwd_pkg::S_CHECK: begin
        state_d = lzwd_pkg::S_FETCH;
        if (sum_base > exp_w) begin
          phase_d = lzwd_pkg::PH_FAIL;
          err_d   = lzwd_pkg::ERR_OVERRUN;
        end else if (prev_q != CBW'(lzwd_pkg::CODE_CLEAR)) begin
          if (32'(next_q) >= MAX_CODES) begin
            phase_d = lzwd_pkg::PH_FAIL;
            err_d   = lzwd_pkg::ERR_FULL;
          end else begin
            dict_we = 1'b1;
            next_d  = next_q + (AW + 1)'(1);
            if (spec_q && sum_n > exp_w) begin
              phase_d = lzwd_pkg::PH_FAIL;
              err_d   = lzwd_pkg::ERR_OVERRUN;
            end else begin
              if (32'(cw_q) < CBW && NW'(next_d) == (NW'(1) << cw_q)) begin
                cw_d = cw_q + WW'(1);
              end
              prev_d  = code_q;
              depth_d = n_q;
            end
          end
        end else begin
          prev_d  = code_q;
          depth_d = n_q;
        end
      end

      lzwd_pkg::S_POP: begin
        depth_d = depth_q - (AW + 1)'(1);
        cnt_d   = cnt_q + SZW'(1);
        bpend_d = 1'b1;
        state_d = lzwd_pkg::S_RESP;
      end

      lzwd_pkg::S_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          bpend_d  = 1'b0;
          state_d  = lzwd_pkg::S_IDLE;
          priority if (bpend_q) begin
            out_d = '{lzwd_pkg::ST_BYTE, stk_rd_q, err_q, cnt_q};
          end else if (phase_q == lzwd_pkg::PH_DONE) begin
            out_d = '{lzwd_pkg::ST_DONE, 8'd0, err_q, cnt_q};
          end else if (phase_q == lzwd_pkg::PH_FAIL) begin
            out_d = '{lzwd_pkg::ST_FAIL, 8'd0, err_q, cnt_q};
          end else begin
            out_d = '{lzwd_pkg::ST_NEED, 8'd0, err_q, cnt_q};
          end
        end
      end

      default: state_d = lzwd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzwd_pkg::S_IDLE;
      phase_q     <= lzwd_pkg::PH_START;
      bbuf_q      <= '0;
      bcnt_q      <= '0;
      cw_q        <= WW'(lzwd_pkg::START_WIDTH);
      next_q      <= (AW + 1)'(lzwd_pkg::CODE_FIRST);
      prev_q      <= CBW'(lzwd_pkg::CODE_CLEAR);
      first_q     <= '0;
      depth_q     <= '0;
      cnt_q       <= '0;
      err_q       <= lzwd_pkg::ERR_NONE;
      ended_q     <= 1'b0;
      bpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      bbuf_q  <= bbuf_d;
      bcnt_q  <= bcnt_d;
      cw_q    <= cw_d;
      next_q  <= next_d;
      prev_q  <= prev_d;
      first_q <= first_d;
      depth_q <= (phase_d == lzwd_pkg::PH_FAIL) ? '0 : depth_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      ended_q <= ended_d;
      bpend_q <= bpend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    code_q <= code_d;
    n_q    <= n_d;
    spec_q <= spec_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/lzwd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the LZW decoder, bound to the top level.
module lzwd_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lzwd_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != lzwd_pkg::ST_BYTE |-> out_data_o.out_byte == 8'd0)
    else $error("out_byte set without a byte beat");

  a_fail_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == lzwd_pkg::ST_FAIL
      |-> out_data_o.error_kind != lzwd_pkg::ERR_NONE)
    else $error("failed stream without error code");

  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == lzwd_pkg::ST_DONE
      |-> out_data_o.error_kind == lzwd_pkg::ERR_NONE)
    else $error("finished stream with error code");

endmodule

bind lzw_decompressor_9_to_12_bit lzwd_props u_lzwd_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ verif/lzwd_checker.sv @@
`timescale 1ns / 1ps
// Checker for the LZW decoder: tracks the stream state and compares every result beat.
module lzwd_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lzwd_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lzwd_pkg::out_item_t out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output int                  fail_count_o,
  output int                  results_due_o
);

  localparam int DICT_SIZE = 4096;
  localparam int MAX_WIDTH = 12;

  // decoder state at the block's widths
  logic [lzwd_pkg::SIZE_W-1:0] size_limit;
  logic [18:0]       bit_buf;
  logic [4:0]        bit_cnt;
  logic [3:0]        width;
  logic [12:0]       next_free;
  logic [11:0]       prev_code;
  logic [7:0]        lead_byte;
  logic [19:0]       dict [DICT_SIZE];   // {prefix, byte}
  logic [7:0]        stack [DICT_SIZE];
  logic [12:0]       depth;
  logic [lzwd_pkg::SIZE_W-1:0] produced;
  lzwd_pkg::phase_e  phase;
  logic [2:0]        err_code;
  bit                ended;

  lzwd_pkg::out_item_t results_due [$];
  int fail_count = 0;

  assign fail_count_o  = fail_count;
  assign results_due_o = results_due.size();

  task automatic abort_stream(input logic [2:0] err);
    phase    = lzwd_pkg::PH_FAIL;
    err_code = err;
    depth    = '0;
  endtask

  task automatic restart_dict();
    width     = lzwd_pkg::START_WIDTH;
    next_free = lzwd_pkg::CODE_FIRST;
    prev_code = lzwd_pkg::CODE_CLEAR;
  endtask

  task automatic clear_stream();
    bit_buf   = '0;
    bit_cnt   = '0;
    restart_dict();
    lead_byte = '0;
    depth     = '0;
    produced  = '0;
    phase     = lzwd_pkg::PH_START;
    err_code  = lzwd_pkg::ERR_NONE;
    ended     = 1'b0;
  endtask

  task automatic take_code(input logic [11:0] code);
    int unsigned special, src, n, c, base;
    if (phase == lzwd_pkg::PH_START) begin
      if (code == lzwd_pkg::CODE_STOP) begin
        if (size_limit == 0) phase = lzwd_pkg::PH_DONE;
        else abort_stream(lzwd_pkg::ERR_LENGTH);
      end else if (code == lzwd_pkg::CODE_CLEAR) begin
        restart_dict();
        phase = lzwd_pkg::PH_RUN;
      end else begin
        abort_stream(lzwd_pkg::ERR_START);
      end
      return;
    end
    if (code == lzwd_pkg::CODE_STOP) begin
      if (produced == size_limit) phase = lzwd_pkg::PH_DONE;
      else abort_stream(lzwd_pkg::ERR_LENGTH);
      return;
    end
    if (code == lzwd_pkg::CODE_CLEAR) begin
      restart_dict();
      return;
    end
    if (code > next_free) begin
      abort_stream(lzwd_pkg::ERR_BIG);
      return;
    end
    special = (code == next_free) ? 1 : 0;
    src = special ? prev_code : code;
    if (src == lzwd_pkg::CODE_CLEAR) begin
      abort_stream(lzwd_pkg::ERR_SPECIAL);
      return;
    end
    // walk the chain back to its root byte
    n = special;
    c = src;
    while (c >= lzwd_pkg::CODE_FIRST) begin
      if (c >= DICT_SIZE || n >= DICT_SIZE) begin
        abort_stream(lzwd_pkg::ERR_BIG);
        return;
      end
      stack[n] = dict[c][7:0];
      n++;
      c = dict[c][19:8];
    end
    if (c > 8'hFF || n >= DICT_SIZE) begin
      abort_stream(lzwd_pkg::ERR_BIG);
      return;
    end
    stack[n] = 8'(c);
    n++;
    lead_byte = 8'(c);
    if (special) stack[0] = 8'(c);
    base = n - special;
    if (32'(produced) + base > 32'(size_limit)) begin
      abort_stream(lzwd_pkg::ERR_OVERRUN);
      return;
    end
    if (prev_code != lzwd_pkg::CODE_CLEAR) begin
      if (next_free >= DICT_SIZE) begin
        abort_stream(lzwd_pkg::ERR_FULL);
        return;
      end
      dict[next_free] = {prev_code, lead_byte};
      next_free++;
      if (special && 32'(produced) + n > 32'(size_limit)) begin
        abort_stream(lzwd_pkg::ERR_OVERRUN);
        return;
      end
      if (width < MAX_WIDTH && 32'(next_free) == (32'd1 << width)) width++;
    end
    prev_code = code;
    depth = 13'(n);
  endtask

  task automatic decode_beat(input lzwd_pkg::in_item_t item,
                             output lzwd_pkg::out_item_t res);
    logic [2:0]  st;
    logic [7:0]  ob;
    logic [11:0] code;
    st = lzwd_pkg::ST_OK;
    ob = '0;
    if (item.kind == lzwd_pkg::KIND_RESTART) begin
      clear_stream();
    end else if (phase == lzwd_pkg::PH_DONE || phase == lzwd_pkg::PH_FAIL) begin
      st = (phase == lzwd_pkg::PH_DONE) ? lzwd_pkg::ST_DONE : lzwd_pkg::ST_FAIL;
    end else if (item.kind == lzwd_pkg::KIND_PUSH) begin
      if (ended || 32'(bit_cnt) + 8 > 19) begin
        st = lzwd_pkg::ST_REFUSED;
      end else begin
        bit_buf |= 19'(item.data_byte) << bit_cnt;
        bit_cnt += 5'd8;
      end
    end else if (item.kind == lzwd_pkg::KIND_END) begin
      ended = 1'b1;
    end else begin
      // codes are decoded only when the stack has run dry
      while (depth == 0 && (phase == lzwd_pkg::PH_START || phase == lzwd_pkg::PH_RUN)) begin
        if (bit_cnt < width) begin
          if (ended) abort_stream(lzwd_pkg::ERR_TRUNC);
          break;
        end
        code = 12'(bit_buf & ((19'd1 << width) - 19'd1));
        bit_buf = bit_buf >> width;
        bit_cnt = bit_cnt - 5'(width);
        take_code(code);
      end
      if (depth > 0) begin
        depth--;
        ob = stack[depth];
        produced++;
        st = lzwd_pkg::ST_BYTE;
      end else if (phase == lzwd_pkg::PH_DONE || phase == lzwd_pkg::PH_FAIL) begin
        st = (phase == lzwd_pkg::PH_DONE) ? lzwd_pkg::ST_DONE : lzwd_pkg::ST_FAIL;
      end else begin
        st = lzwd_pkg::ST_NEED;
      end
    end
    res = '{status: st, out_byte: ob, error_kind: err_code, bytes_written: produced};
  endtask

  task automatic note_fail(input string what, input int unsigned want, input int unsigned got);
    $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lzwd_pkg::out_item_t res;
    lzwd_pkg::out_item_t want;
    if (!rst_ni) begin
      size_limit = '0;
      clear_stream();
      results_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == 3'({lzwd_pkg::ADDR_EXPECTED, 2'b00}))
        size_limit = pwdata_i[lzwd_pkg::SIZE_W-1:0];
      if (in_valid_i && in_ready_i) begin
        decode_beat(in_data_i, res);
        results_due.push_back(res);
      end
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          note_fail("unexpected beat, status", 0, out_data_i.status);
        end else begin
          want = results_due.pop_front();
          if (out_data_i.status != want.status)
            note_fail("status", want.status, out_data_i.status);
          if (out_data_i.out_byte != want.out_byte)
            note_fail("out_byte", want.out_byte, out_data_i.out_byte);
          if (out_data_i.error_kind != want.error_kind)
            note_fail("error_kind", want.error_kind, out_data_i.error_kind);
          if (out_data_i.bytes_written != want.bytes_written)
            note_fail("bytes_written", want.bytes_written, out_data_i.bytes_written);
        end
      end
    end
  end

endmodule

@@ verif/lzw_decompressor_9_to_12_bit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the LZW decoder: stream encoder, beat pacing and verdict.
module lzw_decompressor_9_to_12_bit_test;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DICT_LIMIT  = 4096;
  localparam int RANDOM_BEATS = 1150;
  localparam int TOP_SIZE    = 16777216;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  lzwd_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_ready;
  lzwd_pkg::out_item_t out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          results_due;
  int unsigned beats_in = 0;   // input beats accepted
  int unsigned beats_out = 0;  // result beats taken
  logic [2:0]  last_status = lzwd_pkg::ST_OK;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;

  // encoder scratch: compressed bytes and the decoder's code width as it will see it
  logic [7:0]  packed_stream [$];
  logic [7:0]  plain_text [$];
  int unsigned bit_acc, bit_cnt, dec_width, dec_next;
  bit          dec_fresh;
  int unsigned enc_dict [int unsigned];

  always #2 clk_i = ~clk_i;

  lzw_decompressor_9_to_12_bit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  lzwd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .results_due_o(results_due)
  );

  // Result side: random stalls, or a long hold-off counted here when asked for.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Count result beats; the status of the newest one steers the stream driver.
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      last_status <= out_data.status;
    end
  end

  // Idle mix: sender light / receiver heavy, then swapped, then none.
  task automatic pace();
    if (beats_in < 450) begin
      send_idle_pct = 7;
      recv_idle_pct = 61;
    end else if (beats_in < 900) begin
      send_idle_pct = 61;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Offer one beat and hold it until accepted. Valid is left high afterwards.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] value);
    pace();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, data_byte: value};
    do @(posedge clk_i); while (!in_ready);
    beats_in++;
  endtask

  task automatic wait_all();
    while (beats_out != beats_in) @(posedge clk_i);
  endtask

  // One beat, then wait for its answer in last_status.
  task automatic exchange(input logic [1:0] kind, input logic [7:0] value);
    send_item(kind, value);
    in_valid <= 1'b0;
    wait_all();
  endtask

  // Register write: setup cycle then access cycle; only called with the block idle.
  task automatic apb_write(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'({lzwd_pkg::ADDR_EXPECTED, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic start_pack();
    packed_stream.delete();
    bit_acc   = 0;
    bit_cnt   = 0;
    dec_width = lzwd_pkg::START_WIDTH;
    dec_next  = lzwd_pkg::CODE_FIRST;
    dec_fresh = 1'b1;
  endtask

  // Append a code LSB first at the width the decoder will read it with.
  task automatic put_code(input int unsigned code);
    bit_acc |= code << bit_cnt;
    bit_cnt += dec_width;
    while (bit_cnt >= 8) begin
      packed_stream.push_back(8'(bit_acc));
      bit_acc >>= 8;
      bit_cnt -= 8;
    end
    if (code == lzwd_pkg::CODE_CLEAR) begin
      dec_width = lzwd_pkg::START_WIDTH;
      dec_next  = lzwd_pkg::CODE_FIRST;
      dec_fresh = 1'b1;
    end else if (code != lzwd_pkg::CODE_STOP) begin
      // decoder adds an entry on every code but the first after a clear
      if (!dec_fresh) begin
        dec_next++;
        if (dec_width < 12 && dec_next == (32'd1 << dec_width)) dec_width++;
      end
      dec_fresh = 1'b0;
    end
  endtask

  task automatic finish_pack();
    if (bit_cnt > 0) packed_stream.push_back(8'(bit_acc));
  endtask

  // Plain LZW over plain_text, optional clear before index clear_at.
  task automatic encode_text(input int clear_at);
    int unsigned phrase, next_free, key;
    logic [7:0]  ch;
    start_pack();
    put_code(lzwd_pkg::CODE_CLEAR);
    enc_dict.delete();
    next_free = lzwd_pkg::CODE_FIRST;
    if (plain_text.size() > 0) begin
      phrase = plain_text[0];
      for (int i = 1; i < plain_text.size(); i++) begin
        ch = plain_text[i];
        if (i == clear_at) begin
          put_code(phrase);
          put_code(lzwd_pkg::CODE_CLEAR);
          enc_dict.delete();
          next_free = lzwd_pkg::CODE_FIRST;
          phrase = ch;
        end else begin
          key = phrase * 256 + ch;
          if (enc_dict.exists(key)) begin
            phrase = enc_dict[key];
          end else begin
            put_code(phrase);
            // once full the encoder stops growing; the decoder flags dictionary full
            if (next_free < DICT_LIMIT) begin
              enc_dict[key] = next_free;
              next_free++;
            end
            phrase = ch;
          end
        end
      end
      put_code(phrase);
    end
    put_code(lzwd_pkg::CODE_STOP);
    finish_pack();
  endtask

  // Feed packed_stream one beat at a time, mixing pushes and pulls at random; a bounced push is retried.
  task automatic run_stream(input int unsigned size);
    int unsigned pos;
    apb_write(size);
    exchange(lzwd_pkg::KIND_RESTART, 8'($urandom));
    pos = 0;
    forever begin
      if (pos < packed_stream.size() && $urandom_range(2) != 0) begin
        exchange(lzwd_pkg::KIND_PUSH, packed_stream[pos]);
        if (last_status == lzwd_pkg::ST_OK) pos++;
        else if (last_status != lzwd_pkg::ST_REFUSED) break;
      end else begin
        exchange(lzwd_pkg::KIND_PULL, 8'($urandom));
        if (last_status == lzwd_pkg::ST_DONE || last_status == lzwd_pkg::ST_FAIL) break;
        if (last_status == lzwd_pkg::ST_NEED && pos >= packed_stream.size()) begin
          // out of input: mark the end, the next pull reports truncation
          exchange(lzwd_pkg::KIND_END, 8'($urandom));
          exchange(lzwd_pkg::KIND_PULL, 8'($urandom));
          break;
        end
      end
    end
    // a closed stream answers with its final status
    exchange(lzwd_pkg::KIND_PUSH, 8'($urandom));
  endtask

  initial begin
    int unsigned n, alpha, first, size, idx;
    int          clear_at;
    rst_ni  <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stream: stop code first, with and without a zero size
    start_pack();
    put_code(lzwd_pkg::CODE_STOP);
    finish_pack();
    run_stream(0);
    run_stream(3);
    // bad start: all-ones code; a third push can bounce on a full bit buffer
    packed_stream = '{8'hFF, 8'hFF, 8'hFF};
    run_stream(TOP_SIZE);
    // KwKwK straight after a clear
    start_pack();
    put_code(lzwd_pkg::CODE_CLEAR);
    put_code(lzwd_pkg::CODE_FIRST);
    finish_pack();
    run_stream(1);
    // code above the next free entry
    start_pack();
    put_code(lzwd_pkg::CODE_CLEAR);
    put_code(8'h41);
    put_code(lzwd_pkg::CODE_FIRST + 1);
    finish_pack();
    run_stream(2);
    // legal KwKwK byte 00 + 00 00: exact size, then one short (overrun)
    start_pack();
    put_code(lzwd_pkg::CODE_CLEAR);
    put_code(8'h00);
    put_code(lzwd_pkg::CODE_FIRST);
    put_code(lzwd_pkg::CODE_STOP);
    finish_pack();
    run_stream(3);
    run_stream(2);
    // no stop code: end mark then truncation
    start_pack();
    put_code(lzwd_pkg::CODE_CLEAR);
    put_code(8'hFF);
    finish_pack();
    run_stream(1);

    // random well-formed streams, some sized wrong, corrupted or cut short
    while (beats_in < RANDOM_BEATS) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(200, 320) : $urandom_range(0, 40);
      case ($urandom_range(3))
        0:       alpha = 1;
        1:       alpha = 3;
        2:       alpha = 16;
        default: alpha = 256;
      endcase
      first = $urandom_range(255);
      plain_text.delete();
      repeat (n) plain_text.push_back(8'(first + $urandom_range(alpha - 1)));
      clear_at = ($urandom_range(3) == 0 && n > 2) ? $urandom_range(1, n - 1) : -1;
      encode_text(clear_at);
      size = n;
      case ($urandom_range(7))
        6:       size = (n > 0) ? n - 1 : 1;
        7:       size = n + 1;
        default: size = n;
      endcase
      if ($urandom_range(7) == 0) begin
        idx = $urandom_range(packed_stream.size() - 1);
        packed_stream[idx][$urandom_range(7)] ^= 1'b1;
      end
      if ($urandom_range(9) == 0 && packed_stream.size() > 1) void'(packed_stream.pop_back());
      run_stream(size);
    end

    // back-pressure: receiver holds off while beats keep coming
    plain_text.delete();
    repeat (60) plain_text.push_back(8'($urandom_range(1)));
    encode_text(-1);
    apb_write(60);
    exchange(lzwd_pkg::KIND_RESTART, 8'($urandom));
    hold_req = 1'b1;
    foreach (packed_stream[i]) begin
      send_item(lzwd_pkg::KIND_PUSH, packed_stream[i]);
      repeat ($urandom_range(2)) send_item(lzwd_pkg::KIND_PULL, 8'($urandom));
    end
    repeat (80) send_item(lzwd_pkg::KIND_PULL, 8'($urandom));
    send_item(lzwd_pkg::KIND_END, 8'($urandom));
    send_item(lzwd_pkg::KIND_PULL, 8'($urandom));
    send_item(lzwd_pkg::KIND_RESTART, 8'($urandom));
    in_valid <= 1'b0;
    wait_all();

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
